### rtl/lcf_pkg.sv
// ----------------------------------------------------------------------------
// lcf_pkg: shared constants for the LED color crossfade
// Channel layout, function codes and datapath widths.
// ----------------------------------------------------------------------------
package lcf_pkg;

   localparam int MAX_SQUARES_DEF = 32;
   localparam int NUM_CH          = 4;
   localparam int CH_W            = 8;
   localparam int COLOR_W         = NUM_CH * CH_W;
   // square counter: holds 0..64
   localparam int CNT_W           = 7;
   // |to-from| * elapsed + length/2 stays below 2^41
   localparam int NUM_W           = 41;

   localparam logic [1:0] FUNC_STAGE  = 2'd0;
   localparam logic [1:0] FUNC_START  = 2'd1;
   localparam logic [1:0] FUNC_RENDER = 2'd2;

endpackage

### rtl/lcf_if.sv
// ----------------------------------------------------------------------------
// lcf_if: channel interfaces of the LED color crossfade
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface lcf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [4:0]  square_index;
   logic [7:0]  target_c0;
   logic [7:0]  target_c1;
   logic [7:0]  target_c2;
   logic [7:0]  target_c3;
   logic [63:0] now_us;
   logic [31:0] span_us;

   modport source(output valid, func, square_index, target_c0, target_c1, target_c2,
                  target_c3, now_us, span_us, input ready);
   modport sink(input valid, func, square_index, target_c0, target_c1, target_c2,
                target_c3, now_us, span_us, output ready);
endinterface

interface lcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] out_square;
   logic [7:0] out_c0;
   logic [7:0] out_c1;
   logic [7:0] out_c2;
   logic [7:0] out_c3;
   logic       content_ok;
   logic       square_valid;
   logic       last;

   modport source(output valid, out_square, out_c0, out_c1, out_c2, out_c3, content_ok,
                  square_valid, last, input ready);
   modport sink(input valid, out_square, out_c0, out_c1, out_c2, out_c3, content_ok,
                square_valid, last, output ready);
endinterface

interface lcf_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] square_count;

   modport source(output valid, square_count, input ready);
   modport sink(input valid, square_count, output ready);
endinterface

### rtl/lcf_ram.sv
// ----------------------------------------------------------------------------
// lcf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lcf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/led_color_crossfade.sv
// ----------------------------------------------------------------------------
// led_color_crossfade: per-square four-channel LED color crossfade
// Stages targets, starts fades and renders frames from four color RAMs.
// ----------------------------------------------------------------------------
// Staging a target is a single write to the staging RAM. Starting a fade
// sweeps every square through the RAMs, one read state and one write state
// per entry. A frame renders one square at a time: a RAM read state, a
// multiply state, the restoring divider for all eight quotient bits (four
// channel lanes side by side), a write-back state and the output register,
// which holds until rsp_bus.ready. A new request is taken only once the
// previous one has fully finished. Each color RAM keeps a valid bit per entry
// so that never-written entries read as zero.
module led_color_crossfade
   import lcf_pkg::*;
#(
   parameter int MAX_SQUARES = MAX_SQUARES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lcf_req_if.sink   req_bus,
   lcf_rsp_if.source rsp_bus,
   lcf_csr_if.sink   csr_bus
);

   localparam int AW = (MAX_SQUARES > 1) ? $clog2(MAX_SQUARES) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_COPY_RD, S_COPY_WR, S_RD, S_LOAD, S_DIV, S_FIN, S_OUT
   } state_type;

   state_type state_ff;

   logic [5:0]             sq_count_ff;
   logic [CNT_W-1:0]       idx_ff;
   logic [63:0]            start_time_ff;
   logic [31:0]            length_ff;
   logic                   content_ff;
   logic [63:0]            elapsed_ff;
   logic [2:0]             bit_ff;

   logic [MAX_SQUARES-1:0] stg_vld_ff, sta_vld_ff, end_vld_ff, shw_vld_ff;
   logic                   stg_rv_ff, sta_rv_ff, end_rv_ff, shw_rv_ff;

   logic [CH_W-1:0]        from_ff [NUM_CH];
   logic [CH_W-1:0]        to_ff   [NUM_CH];
   logic                   sgn_ff  [NUM_CH];
   logic [NUM_W-1:0]       rem_ff  [NUM_CH];
   logic [CH_W-1:0]        quo_ff  [NUM_CH];

   logic                   rsp_valid_ff;
   logic [4:0]             rsp_square_ff;
   logic [CH_W-1:0]        rsp_c_ff [NUM_CH];
   logic                   rsp_content_ff, rsp_sqv_ff, rsp_last_ff;

   // RAM ports
   logic [AW-1:0]          addr;
   logic [AW-1:0]          stg_wr_addr;
   logic                   stg_we, sta_we, end_we, shw_we;
   logic [COLOR_W-1:0]     stg_wr_data, shw_wr_data;
   logic [COLOR_W-1:0]     stg_rd, sta_rd, end_rd, shw_rd;

   // misc combinational
   logic                   req_fire, rsp_fire;
   logic [CNT_W-1:0]       n_act;
   logic [CNT_W-1:0]       idx_w;
   logic [CNT_W-1:0]       idx_next;
   logic                   idx_active, idx_last;
   logic                   finished;
   logic [63:0]            elapsed_in;
   logic [CNT_W-1:0]       stage_idx;
   logic                   stage_ok;
   logic [CH_W-1:0]        from_c  [NUM_CH];
   logic [CH_W-1:0]        to_c    [NUM_CH];
   logic [CH_W-1:0]        mag_c   [NUM_CH];
   logic                   sgn_c   [NUM_CH];
   logic [CH_W+31:0]       prod_c  [NUM_CH];
   logic [NUM_W-1:0]       num_c   [NUM_CH];
   logic [NUM_W-1:0]       cand;
   logic [CH_W-1:0]        ch_out  [NUM_CH];

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_valid_ff && rsp_bus.ready;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   // clamp square count to the store depth
   assign n_act = (CNT_W'(sq_count_ff) > CNT_W'(MAX_SQUARES)) ? CNT_W'(MAX_SQUARES)
                                                                 : CNT_W'(sq_count_ff);
   assign idx_w      = idx_ff;
   assign idx_next   = idx_ff + CNT_W'(1);
   assign idx_active = idx_w < n_act;
   assign idx_last   = idx_next == n_act;
   assign addr       = idx_ff[AW-1:0];

   assign stage_idx   = CNT_W'(req_bus.square_index);
   assign stage_ok    = stage_idx < CNT_W'(MAX_SQUARES);
   assign stg_wr_addr = stage_idx[AW-1:0];
   assign stg_wr_data = {req_bus.target_c3, req_bus.target_c2,
                         req_bus.target_c1, req_bus.target_c0};

   assign elapsed_in = (req_bus.now_us > start_time_ff) ? req_bus.now_us - start_time_ff
                                                        : 64'd0;
   assign finished   = (length_ff == 32'd0) || (elapsed_ff >= {32'd0, length_ff});

   assign stg_we = (state_ff == S_IDLE) && req_fire && (req_bus.func == FUNC_STAGE)
                   && stage_ok;
   assign sta_we = (state_ff == S_COPY_WR);
   assign end_we = (state_ff == S_COPY_WR) && idx_active;
   assign shw_we = (state_ff == S_FIN);

   // lane operands from the fade RAMs, then |to-from|*elapsed + length/2
   always_comb begin
      for (int l = 0; l < NUM_CH; l++) begin
         from_c[l] = sta_rv_ff ? sta_rd[l*CH_W +: CH_W] : '0;
         to_c[l]   = end_rv_ff ? end_rd[l*CH_W +: CH_W] : '0;
         sgn_c[l]  = to_c[l] < from_c[l];
         mag_c[l]  = sgn_c[l] ? from_c[l] - to_c[l] : to_c[l] - from_c[l];
         prod_c[l] = mag_c[l] * elapsed_ff[31:0];
         num_c[l]  = NUM_W'(prod_c[l]) + NUM_W'(length_ff >> 1);
      end
   end

   // divisor shifted to the current quotient bit
   assign cand = NUM_W'(length_ff) << bit_ff;

   // rendered channel values
   always_comb begin
      for (int l = 0; l < NUM_CH; l++) begin
         if (finished) begin
            ch_out[l] = to_ff[l];
         end else begin
            ch_out[l] = sgn_ff[l] ? from_ff[l] - quo_ff[l] : from_ff[l] + quo_ff[l];
         end
      end
   end

   assign shw_wr_data = {ch_out[3], ch_out[2], ch_out[1], ch_out[0]};

   // color stores
   lcf_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_SQUARES), .AW(AW)) u_stg_ram (
      .clock(clock), .wr_en(stg_we), .wr_addr(stg_wr_addr), .wr_data(stg_wr_data),
      .rd_addr(addr), .rd_data(stg_rd));

   lcf_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_SQUARES), .AW(AW)) u_sta_ram (
      .clock(clock), .wr_en(sta_we), .wr_addr(addr),
      .wr_data(shw_rv_ff ? shw_rd : '0), .rd_addr(addr), .rd_data(sta_rd));

   lcf_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_SQUARES), .AW(AW)) u_end_ram (
      .clock(clock), .wr_en(end_we), .wr_addr(addr),
      .wr_data(stg_rv_ff ? stg_rd : '0), .rd_addr(addr), .rd_data(end_rd));

   lcf_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_SQUARES), .AW(AW)) u_shw_ram (
      .clock(clock), .wr_en(shw_we), .wr_addr(addr), .wr_data(shw_wr_data),
      .rd_addr(addr), .rd_data(shw_rd));

   // valid bits, sampled alongside the RAM reads
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= '0;
         sta_vld_ff <= '0;
         end_vld_ff <= '0;
         shw_vld_ff <= '0;
      end else begin
         if (stg_we) stg_vld_ff[stg_wr_addr] <= 1'b1;
         if (sta_we) sta_vld_ff[addr] <= 1'b1;
         if (end_we) end_vld_ff[addr] <= 1'b1;
         if (shw_we) shw_vld_ff[addr] <= 1'b1;
      end
      stg_rv_ff <= stg_vld_ff[addr];
      sta_rv_ff <= sta_vld_ff[addr];
      end_rv_ff <= end_vld_ff[addr];
      shw_rv_ff <= shw_vld_ff[addr];
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_count_ff <= '0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         sq_count_ff <= csr_bus.square_count;
      end
   end

   // sequencer with output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         content_ff    <= 1'b0;
         start_time_ff <= '0;
         length_ff     <= '0;
         idx_ff        <= '0;
         bit_ff        <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  unique case (req_bus.func)
                     FUNC_START: begin
                        start_time_ff <= req_bus.now_us;
                        length_ff     <= req_bus.span_us;
                        content_ff    <= 1'b1;
                        idx_ff        <= '0;
                        state_ff      <= S_COPY_RD;
                     end
                     FUNC_RENDER: begin
                        if (!content_ff || (n_act == '0)) begin
                           rsp_valid_ff   <= 1'b1;
                           rsp_square_ff  <= '0;
                           for (int l = 0; l < NUM_CH; l++) rsp_c_ff[l] <= '0;
                           rsp_content_ff <= content_ff;
                           rsp_sqv_ff     <= 1'b0;
                           rsp_last_ff    <= 1'b1;
                           state_ff       <= S_OUT;
                        end else begin
                           elapsed_ff <= elapsed_in;
                           idx_ff     <= '0;
                           state_ff   <= S_RD;
                        end
                     end
                     default: begin
                        // staging is a RAM write only; code 3 is dropped
                     end
                  endcase
               end
            end
            S_COPY_RD: begin
               state_ff <= S_COPY_WR;
            end
            S_COPY_WR: begin
               if (idx_ff == CNT_W'(MAX_SQUARES - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= S_COPY_RD;
               end
            end
            S_RD: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               for (int l = 0; l < NUM_CH; l++) begin
                  from_ff[l] <= from_c[l];
                  to_ff[l]   <= to_c[l];
                  sgn_ff[l]  <= sgn_c[l];
                  rem_ff[l]  <= num_c[l];
                  quo_ff[l]  <= '0;
               end
               bit_ff   <= 3'd7;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // one restoring step per lane
               for (int l = 0; l < NUM_CH; l++) begin
                  if (rem_ff[l] >= cand) begin
                     rem_ff[l]         <= rem_ff[l] - cand;
                     quo_ff[l][bit_ff] <= 1'b1;
                  end
               end
               bit_ff <= bit_ff - 3'd1;
               if (bit_ff == 3'd0) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               rsp_valid_ff   <= 1'b1;
               rsp_square_ff  <= 5'(idx_ff);
               for (int l = 0; l < NUM_CH; l++) rsp_c_ff[l] <= ch_out[l];
               rsp_content_ff <= 1'b1;
               rsp_sqv_ff     <= 1'b1;
               rsp_last_ff    <= idx_last;
               state_ff       <= S_OUT;
            end
            S_OUT: begin
               if (rsp_fire) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_next;
                     state_ff <= S_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_square   = rsp_square_ff;
   assign rsp_bus.out_c0       = rsp_c_ff[0];
   assign rsp_bus.out_c1       = rsp_c_ff[1];
   assign rsp_bus.out_c2       = rsp_c_ff[2];
   assign rsp_bus.out_c3       = rsp_c_ff[3];
   assign rsp_bus.content_ok   = rsp_content_ff;
   assign rsp_bus.square_valid = rsp_sqv_ff;
   assign rsp_bus.last         = rsp_last_ff;

endmodule
